@@ rtl/tpfe_pkg.sv @@
// Package for the tabulated pair force pipeline: context word, stage map,
// status and register codes, and the fixed-point helper functions.
// Used by tabulated_pair_force_eval_unit; depends on nothing else.
package tpfe_pkg;

	localparam int MaxSplines = 1024;
	localparam int SplineW = 11;
	localparam int TableRows = 16384;
	localparam int NumLanes = 6;
	localparam int NumStages = 76;

	localparam int StSquare = 1;
	localparam int StSum = 2;
	localparam int StRoot0 = 3;
	localparam int RootSteps = 32;
	localparam int StFlags = 35;
	localparam int StScale = 36;
	localparam int StIndex = 37;
	localparam int StDiv0 = 36;
	localparam int DivSteps = 32;
	localparam int StMem = 49;
	localparam int StDeSum = 59;
	localparam int MulLat = 3;

	localparam int GrpHorner1 = 0;
	localparam int GrpHorner2 = 1;
	localparam int GrpEnergy = 2;
	localparam int GrpScale = 3;
	localparam int GrpForce = 4;
	localparam int GrpVirial = 5;
	localparam int NumGroups = 6;
	localparam int MulA [NumGroups] = '{51, 55, 60, 64, 68, 72};
	localparam int MulN [NumGroups] = '{2, 2, 2, 1, 3, 6};

	localparam int VirA [NumLanes] = '{0, 0, 0, 1, 1, 2};
	localparam int VirB [NumLanes] = '{0, 1, 2, 1, 2, 2};

	localparam logic [5:0] FracShift = 6'd32;
	localparam logic [5:0] StepShift = 6'd16;
	localparam logic [5:0] HalfScaleShift = 6'd17;
	localparam logic [5:0] DispShift = 6'd20;

	localparam logic CmdWrite = 1'b0;
	localparam logic CmdEval = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BEYOND = 2'd1,
		ST_BELOW  = 2'd2,
		ST_ZERO   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_RANGE_MIN    = 2'd0,
		REG_INV_STEP     = 2'd1,
		REG_SPLINE_COUNT = 2'd2,
		REG_TYPE_COUNT   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic cmd;
		logic [15:0] addr;
		logic [47:0] coef;
		logic [2:0][31:0] d;
		logic [1:0] ct;
		logic [1:0] nt;
		logic [31:0] scale;
		logic [2:0][63:0] sq;
		logic [63:0] sqv;
		logic [63:0] sqr;
		logic [31:0] rr;
		logic is_zero;
		logic below;
		logic beyond;
		logic [31:0] diff;
		logic [63:0] u;
		logic [31:0] frac;
		logic [13:0] row;
		logic [2:0][31:0] dvr;
		logic [2:0][32:0] dvq;
		logic [3:0][63:0] coefs;
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] e1;
		logic [63:0] de;
		logic [63:0] ener;
		logic [63:0] fs;
		logic [63:0] g;
		logic [2:0][63:0] frc;
		logic [5:0][63:0] vir;
		logic [5:0][63:0] ma;
		logic [5:0][63:0] mb;
		logic [5:0] ng;
		logic [5:0][3:0][63:0] pp;
		logic [5:0][127:0] pr;
	} ctx_t;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic [63:0] sext32(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	// Product magnitude scaled down, truncated toward zero, saturated to 64 bits.
	function automatic logic [63:0] mul_fin(input logic [127:0] prod, input logic neg,
			input logic [5:0] sh);
		logic [127:0] q;
		q = prod >> sh;
		if (neg) begin
			if (|q[127:63]) begin
				return (q[127:0] == 128'(64'h8000_0000_0000_0000)) ? {1'b1, 63'b0}
					: {1'b1, 63'b0};
			end
			return ~q[63:0] + 64'd1;
		end
		if (|q[127:63]) begin
			return {1'b0, {63{1'b1}}};
		end
		return q[63:0];
	endfunction

	function automatic ctx_t set_lane(input ctx_t c, input logic [2:0] l,
			input logic [63:0] a, input logic [63:0] b);
		ctx_t r;
		r = c;
		r.ma[l] = mag64(a);
		r.mb[l] = mag64(b);
		r.ng[l] = a[63] ^ b[63];
		return r;
	endfunction

endpackage

@@ rtl/tabulated_pair_force_eval_unit.sv @@
// Top level of the tabulated pair force pipeline: table memory, root and
// divide stages, spline evaluation and force and virial products.
// Depends on tpfe_pkg.
// Accepts one word per cycle while the output is not stalled.
// Depth is set by the 32-stage square root and the 32-stage unit vector divide.
// A stalled output holds every stage; a write word updates the table at stage 49.
// Reset clears valid bits and loads the register defaults; the table is undefined.
module tabulated_pair_force_eval_unit import tpfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic [15:0] coef_addr,
	input  logic signed [47:0] coef_value,
	input  logic signed [31:0] disp_x,
	input  logic signed [31:0] disp_y,
	input  logic signed [31:0] disp_z,
	input  logic [1:0] center_type,
	input  logic [1:0] neighbor_type,
	input  logic signed [31:0] atom_scale,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic signed [63:0] pair_energy_half,
	output logic signed [63:0] force_scale,
	output logic signed [63:0] force_x,
	output logic signed [63:0] force_y,
	output logic signed [63:0] force_z,
	output logic signed [63:0] virial_xx,
	output logic signed [63:0] virial_xy,
	output logic signed [63:0] virial_xz,
	output logic signed [63:0] virial_yy,
	output logic signed [63:0] virial_yz,
	output logic signed [63:0] virial_zz
);

	logic [31:0] range_min_q;
	logic [31:0] inv_step_q;
	logic [SplineW-1:0] spline_count_q;
	logic [2:0] type_count_q;
	logic [SplineW-1:0] splines_eff;

	logic adv;
	logic out_valid_q;
	ctx_t pl_s [NumStages];
	ctx_t nx [NumStages];
	logic [NumStages-1:0] vld_s;

	logic [47:0] coef_mem [4][TableRows];
	logic [3:0][47:0] coef_rd_q;

	ctx_t lst;
	status_t st;
	logic [63:0] eh;

	logic [1:0] status_q;
	logic [63:0] energy_q, fscale_q;
	logic [2:0][63:0] force_q;
	logic [5:0][63:0] virial_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= '0;
			inv_step_q <= 32'd65536;
			spline_count_q <= '0;
			type_count_q <= 3'd1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE_MIN: range_min_q <= cfg_data;
				REG_INV_STEP: inv_step_q <= cfg_data;
				REG_SPLINE_COUNT: spline_count_q <= cfg_data[SplineW-1:0];
				REG_TYPE_COUNT: type_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign splines_eff = (spline_count_q > SplineW'(MaxSplines)) ? SplineW'(MaxSplines)
		: spline_count_q;

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		logic [31:0] m;
		logic [63:0] rb;
		logic [63:0] rbit;
		logic [32:0] dt;
		logic [27:0] idx;
		logic [5:0] tp;
		logic [16:0] tsp;
		logic [63:0] fx;
		logic [63:0] unit;
		m = '0;
		rb = '0;
		rbit = '0;
		dt = '0;
		idx = '0;
		tp = '0;
		tsp = '0;
		fx = '0;
		unit = '0;

		nx[0] = '0;
		nx[0].cmd = cmd;
		nx[0].addr = coef_addr;
		nx[0].coef = coef_value;
		nx[0].d[0] = disp_x;
		nx[0].d[1] = disp_y;
		nx[0].d[2] = disp_z;
		nx[0].ct = center_type;
		nx[0].nt = neighbor_type;
		nx[0].scale = atom_scale;

		for (int i = 1; i < NumStages; i++) begin
			nx[i] = pl_s[i-1];
			fx = {32'b0, pl_s[i-1].frac};

			if (i == StSquare) begin
				for (int c = 0; c < 3; c++) begin
					m = mag32(pl_s[i-1].d[c]);
					nx[i].sq[c] = 64'(m) * 64'(m);
				end
			end

			if (i == StSum) begin
				nx[i].sqv = pl_s[i-1].sq[0] + pl_s[i-1].sq[1] + pl_s[i-1].sq[2];
				nx[i].sqr = '0;
			end

			if (i >= StRoot0 && i < StRoot0 + RootSteps) begin
				rbit = 64'd1 << (62 - 2 * (i - StRoot0));
				rb = pl_s[i-1].sqr + rbit;
				if (pl_s[i-1].sqv >= rb) begin
					nx[i].sqv = pl_s[i-1].sqv - rb;
					nx[i].sqr = (pl_s[i-1].sqr >> 1) + rbit;
				end else begin
					nx[i].sqr = pl_s[i-1].sqr >> 1;
				end
			end

			if (i == StFlags) begin
				nx[i].rr = pl_s[i-1].sqr[31:0];
				nx[i].is_zero = (pl_s[i-1].sqr[31:0] == 32'd0);
				nx[i].below = (pl_s[i-1].sqr[31:0] < range_min_q);
				nx[i].diff = pl_s[i-1].sqr[31:0] - range_min_q;
				for (int c = 0; c < 3; c++) begin
					m = mag32(pl_s[i-1].d[c]);
					if (m >= pl_s[i-1].sqr[31:0]) begin
						nx[i].dvr[c] = m - pl_s[i-1].sqr[31:0];
						nx[i].dvq[c] = 33'd1;
					end else begin
						nx[i].dvr[c] = m;
						nx[i].dvq[c] = 33'd0;
					end
				end
			end

			if (i == StScale) begin
				nx[i].u = 64'(pl_s[i-1].diff) * 64'(inv_step_q);
			end

			if (i >= StDiv0 && i < StDiv0 + DivSteps) begin
				for (int c = 0; c < 3; c++) begin
					dt = {pl_s[i-1].dvr[c], 1'b0};
					if (dt >= {1'b0, pl_s[i-1].rr}) begin
						nx[i].dvr[c] = 32'(dt - {1'b0, pl_s[i-1].rr});
						nx[i].dvq[c] = {pl_s[i-1].dvq[c][31:0], 1'b1};
					end else begin
						nx[i].dvr[c] = dt[31:0];
						nx[i].dvq[c] = {pl_s[i-1].dvq[c][31:0], 1'b0};
					end
				end
			end

			if (i == StIndex) begin
				idx = pl_s[i-1].u[63:36];
				nx[i].frac = pl_s[i-1].u[35:4];
				nx[i].beyond = (idx >= {17'b0, splines_eff});
				tp = 6'(pl_s[i-1].ct) * 6'(type_count_q) + 6'(pl_s[i-1].nt);
				tsp = 17'(tp) * 17'(splines_eff);
				nx[i].row = tsp[13:0] + idx[13:0];
			end

			for (int g = 0; g < NumGroups; g++) begin
				if (i == MulA[g] + 1) begin
					for (int l = 0; l < MulN[g]; l++) begin
						nx[i].pp[l][0] = 64'(pl_s[i-1].ma[l][31:0]) * 64'(pl_s[i-1].mb[l][31:0]);
						nx[i].pp[l][1] = 64'(pl_s[i-1].ma[l][31:0]) * 64'(pl_s[i-1].mb[l][63:32]);
						nx[i].pp[l][2] = 64'(pl_s[i-1].ma[l][63:32]) * 64'(pl_s[i-1].mb[l][31:0]);
						nx[i].pp[l][3] = 64'(pl_s[i-1].ma[l][63:32]) * 64'(pl_s[i-1].mb[l][63:32]);
					end
				end
				if (i == MulA[g] + 2) begin
					for (int l = 0; l < MulN[g]; l++) begin
						nx[i].pr[l] = 128'(pl_s[i-1].pp[l][0])
							+ (128'(pl_s[i-1].pp[l][1]) << 32)
							+ (128'(pl_s[i-1].pp[l][2]) << 32)
							+ (128'(pl_s[i-1].pp[l][3]) << 64);
					end
				end
			end

			if (i == MulA[GrpHorner1]) begin
				for (int k = 0; k < 4; k++) begin
					nx[i].coefs[k] = {{16{coef_rd_q[k][47]}}, coef_rd_q[k]};
				end
				nx[i] = set_lane(nx[i], 3'd0, {{16{coef_rd_q[0][47]}}, coef_rd_q[0]}, fx);
				nx[i] = set_lane(nx[i], 3'd1, {{15{coef_rd_q[0][47]}}, coef_rd_q[0], 1'b0}, fx);
			end
			if (i == MulA[GrpHorner1] + MulLat) begin
				nx[i].t = sat_add(mul_fin(pl_s[i-1].pr[0], pl_s[i-1].ng[0], FracShift),
					pl_s[i-1].coefs[1]);
				nx[i].p = sat_add(mul_fin(pl_s[i-1].pr[1], pl_s[i-1].ng[1], FracShift),
					pl_s[i-1].coefs[1]);
			end

			if (i == MulA[GrpHorner2]) begin
				nx[i] = set_lane(nx[i], 3'd0, pl_s[i-1].t, fx);
				nx[i] = set_lane(nx[i], 3'd1, pl_s[i-1].p, fx);
			end
			if (i == MulA[GrpHorner2] + MulLat) begin
				nx[i].e1 = sat_add(mul_fin(pl_s[i-1].pr[0], pl_s[i-1].ng[0], FracShift),
					pl_s[i-1].coefs[2]);
				nx[i].de = mul_fin(pl_s[i-1].pr[1], pl_s[i-1].ng[1], FracShift);
			end

			if (i == StDeSum) begin
				nx[i].de = sat_add(pl_s[i-1].de, pl_s[i-1].e1);
			end

			if (i == MulA[GrpEnergy]) begin
				nx[i] = set_lane(nx[i], 3'd0, pl_s[i-1].e1, fx);
				nx[i] = set_lane(nx[i], 3'd1, pl_s[i-1].de, 64'd0 - {32'b0, inv_step_q});
			end
			if (i == MulA[GrpEnergy] + MulLat) begin
				nx[i].ener = sat_add(mul_fin(pl_s[i-1].pr[0], pl_s[i-1].ng[0], FracShift),
					pl_s[i-1].coefs[3]);
				nx[i].fs = mul_fin(pl_s[i-1].pr[1], pl_s[i-1].ng[1], StepShift);
			end

			if (i == MulA[GrpScale]) begin
				nx[i] = set_lane(nx[i], 3'd0, pl_s[i-1].fs, sext32(pl_s[i-1].scale));
			end
			if (i == MulA[GrpScale] + MulLat) begin
				nx[i].g = mul_fin(pl_s[i-1].pr[0], pl_s[i-1].ng[0], HalfScaleShift);
			end

			if (i == MulA[GrpForce]) begin
				for (int c = 0; c < 3; c++) begin
					unit = {31'b0, pl_s[i-1].dvq[c]};
					if (pl_s[i-1].d[c][31]) begin
						unit = ~unit + 64'd1;
					end
					nx[i] = set_lane(nx[i], 3'(c), pl_s[i-1].g, unit);
				end
			end
			if (i == MulA[GrpForce] + MulLat) begin
				for (int c = 0; c < 3; c++) begin
					nx[i].frc[c] = mul_fin(pl_s[i-1].pr[c], pl_s[i-1].ng[c], FracShift);
				end
			end

			if (i == MulA[GrpVirial]) begin
				for (int v = 0; v < NumLanes; v++) begin
					nx[i] = set_lane(nx[i], 3'(v), pl_s[i-1].frc[VirA[v]],
						sext32(pl_s[i-1].d[VirB[v]]));
				end
			end
			if (i == MulA[GrpVirial] + MulLat) begin
				for (int v = 0; v < NumLanes; v++) begin
					nx[i].vir[v] = mul_fin(pl_s[i-1].pr[v], pl_s[i-1].ng[v], DispShift);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NumStages; i++) begin
				pl_s[i] <= nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NumStages-2:0], in_valid};
		end
	end

	// Writes and reads meet the table at one stage, so table order follows word order.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (vld_s[StMem] && pl_s[StMem].cmd == CmdWrite) begin
				coef_mem[pl_s[StMem].addr[1:0]][pl_s[StMem].addr[15:2]] <= pl_s[StMem].coef;
			end
			for (int k = 0; k < 4; k++) begin
				coef_rd_q[k] <= coef_mem[k][pl_s[StMem].row];
			end
		end
	end

	assign lst = pl_s[NumStages-1];

	always_comb begin
		if (lst.is_zero) begin
			st = ST_ZERO;
		end else if (lst.below) begin
			st = ST_BELOW;
		end else if (lst.beyond) begin
			st = ST_BEYOND;
		end else begin
			st = ST_OK;
		end
		eh = lst.ener + 64'(lst.ener[63]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[NumStages-1] && lst.cmd == CmdEval;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= st;
			if (st == ST_OK) begin
				energy_q <= {eh[63], eh[63:1]};
				fscale_q <= lst.fs;
				force_q <= lst.frc;
				virial_q <= lst.vir;
			end else begin
				energy_q <= '0;
				fscale_q <= '0;
				force_q <= '0;
				virial_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign pair_energy_half = energy_q;
	assign force_scale = fscale_q;
	assign force_x = force_q[0];
	assign force_y = force_q[1];
	assign force_z = force_q[2];
	assign virial_xx = virial_q[0];
	assign virial_xy = virial_q[1];
	assign virial_xz = virial_q[2];
	assign virial_yy = virial_q[3];
	assign virial_yz = virial_q[4];
	assign virial_zz = virial_q[5];

endmodule

@@ tb/tb_tabulated_pair_force_eval_unit.sv @@
// Self-checking testbench for tabulated_pair_force_eval_unit: drives write and
// evaluate words under several register settings and compares every result word
// with an in-bench fixed-point predictor. Depends on tpfe_pkg and the RTL top.
module tb_tabulated_pair_force_eval_unit import tpfe_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SMin = 64'sh8000_0000_0000_0000;
	localparam longint SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam int WatchLimit = 20000;
	localparam int DrainCycles = 100;

	typedef struct {
		status_t st;
		longint v[11];
	} pair_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CmdWrite;
	logic [15:0] coef_addr = '0;
	logic signed [47:0] coef_value = '0;
	logic signed [31:0] disp_x = '0, disp_y = '0, disp_z = '0;
	logic [1:0] center_type = '0, neighbor_type = '0;
	logic signed [31:0] atom_scale = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic signed [63:0] pair_energy_half, force_scale, force_x, force_y, force_z;
	logic signed [63:0] virial_xx, virial_xy, virial_xz, virial_yy, virial_yz, virial_zz;

	tabulated_pair_force_eval_unit DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [63:0] cfg_range_min = 0, cfg_inv_step = 65536, cfg_splines = 0, cfg_types = 1;
	longint coef_mem [bit [15:0]];
	pair_result_t expected_pairs [$];
	int mismatches = 0;
	bit src_idle_en = 1'b1, sink_idle_en = 1'b1;
	bit hold_req = 1'b0;
	int hold_len = 0;
	int disp_span = 1 << 20;
	int idle_cycles = 0;

	function automatic longint sat_sum(longint a, longint b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? SMin : SMax;
		return s[63:0];
	endfunction

	// Product scaled down by 2^sh, truncated toward zero and saturated.
	function automatic longint scaled_prod(longint a, longint b, int sh);
		logic [63:0] x, y;
		logic [127:0] q;
		bit neg;
		x = a[63] ? (~a + 64'd1) : a;
		y = b[63] ? (~b + 64'd1) : b;
		neg = a[63] ^ b[63];
		q = ({64'b0, x} * {64'b0, y}) >> sh;
		if (q[127:63] != 0) return neg ? SMin : SMax;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic logic [63:0] int_root(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint table_word(logic [15:0] a);
		return coef_mem.exists(a) ? coef_mem[a] : 0;
	endfunction

	function automatic pair_result_t predict_pair(input logic signed [31:0] dx, dy, dz,
			input logic [1:0] ct, nt, input logic signed [31:0] sc,
			output logic [15:0] rd_base, output bit uses_table);
		pair_result_t res;
		longint d [3];
		longint cf [4];
		longint frc [3];
		logic [63:0] m, r2, r, u, idx, spl, base, num;
		longint f, t, e1, en, de, fs, g, unit;
		res.st = ST_OK;
		foreach (res.v[k]) res.v[k] = 0;
		rd_base = '0;
		uses_table = 1'b0;
		d[0] = dx;
		d[1] = dy;
		d[2] = dz;
		r2 = 0;
		for (int c = 0; c < 3; c++) begin
			m = d[c] < 0 ? -d[c] : d[c];
			r2 += m * m;
		end
		spl = cfg_splines > MaxSplines ? MaxSplines : cfg_splines;
		r = int_root(r2);
		if (r2 == 0) begin
			res.st = ST_ZERO;
		end else if (r < cfg_range_min) begin
			res.st = ST_BELOW;
		end else begin
			u = (r - cfg_range_min) * cfg_inv_step;
			idx = u >> 36;
			if (idx >= spl) begin
				res.st = ST_BEYOND;
			end else begin
				f = {32'b0, u[35:4]};
				base = ((ct * cfg_types + nt) * spl + idx) * 4;
				rd_base = base[15:0];
				uses_table = 1'b1;
				for (int k = 0; k < 4; k++) cf[k] = table_word(16'(rd_base + k));
				t = sat_sum(scaled_prod(cf[0], f, 32), cf[1]);
				e1 = sat_sum(scaled_prod(t, f, 32), cf[2]);
				en = sat_sum(scaled_prod(e1, f, 32), cf[3]);
				de = sat_sum(scaled_prod(sat_sum(scaled_prod(cf[0] * 2, f, 32), cf[1]), f, 32),
					e1);
				fs = scaled_prod(de, -longint'(cfg_inv_step), 16);
				g = scaled_prod(fs, longint'(sc), 17);
				for (int c = 0; c < 3; c++) begin
					m = d[c] < 0 ? -d[c] : d[c];
					num = m << 32;
					unit = num / r;
					if (d[c] < 0) unit = -unit;
					frc[c] = scaled_prod(g, unit, 32);
				end
				res.v[0] = en / 2;
				res.v[1] = fs;
				res.v[2] = frc[0];
				res.v[3] = frc[1];
				res.v[4] = frc[2];
				res.v[5] = scaled_prod(frc[0], d[0], 20);
				res.v[6] = scaled_prod(frc[0], d[1], 20);
				res.v[7] = scaled_prod(frc[0], d[2], 20);
				res.v[8] = scaled_prod(frc[1], d[1], 20);
				res.v[9] = scaled_prod(frc[1], d[2], 20);
				res.v[10] = scaled_prod(frc[2], d[2], 20);
			end
		end
		return res;
	endfunction

	task automatic send_word(logic c, logic [15:0] a, logic [47:0] cv,
			logic [31:0] dx, dy, dz, logic [1:0] ct, nt, logic [31:0] sc);
		pair_result_t res;
		logic [15:0] b;
		bit ut;
		if (src_idle_en && $urandom_range(0, 9) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		cmd = c;
		coef_addr = a;
		coef_value = cv;
		disp_x = dx;
		disp_y = dy;
		disp_z = dz;
		center_type = ct;
		neighbor_type = nt;
		atom_scale = sc;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (c == CmdWrite) begin
			coef_mem[a] = longint'($signed(cv));
		end else begin
			res = predict_pair(dx, dy, dz, ct, nt, sc, b, ut);
			expected_pairs.push_back(res);
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [47:0] rand_coef();
		logic [63:0] w;
		w = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) return w[47:0];
		return 48'(longint'($signed(w[37:0])));
	endfunction

	// Fills any table word the pair would read before the pair itself goes out.
	task automatic send_pair(logic [31:0] dx, dy, dz, logic [1:0] ct, nt, logic [31:0] sc);
		pair_result_t res;
		logic [15:0] b;
		bit ut;
		res = predict_pair(dx, dy, dz, ct, nt, sc, b, ut);
		if (ut) begin
			for (int k = 0; k < 4; k++) begin
				if (!coef_mem.exists(16'(b + k)))
					send_word(CmdWrite, 16'(b + k), rand_coef(), $urandom, $urandom, $urandom,
						2'($urandom), 2'($urandom), $urandom);
			end
		end
		send_word(CmdEval, 16'($urandom), rand_coef(), dx, dy, dz, ct, nt, sc);
	endtask

	task automatic settle();
		while (expected_pairs.size() != 0) @(negedge clk);
		repeat (90) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_RANGE_MIN: cfg_range_min = val;
			REG_INV_STEP: cfg_inv_step = val;
			REG_SPLINE_COUNT: cfg_splines = val & 32'h7FF;
			REG_TYPE_COUNT: cfg_types = val & 32'h7;
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [31:0] rmin, inv, spl, types, int span);
		settle();
		write_reg(REG_RANGE_MIN, rmin);
		write_reg(REG_INV_STEP, inv);
		write_reg(REG_SPLINE_COUNT, spl);
		write_reg(REG_TYPE_COUNT, types);
		disp_span = span;
	endtask

	function automatic logic [31:0] rand_comp(int span);
		return 32'($urandom_range(0, 2 * span)) - 32'(span);
	endfunction

	task automatic test_random_words(int n);
		int sel;
		logic [31:0] sc;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			sc = $urandom_range(0, 1) ? $urandom : rand_comp(1 << 18);
			if (sel < 15)
				send_word(CmdWrite, 16'($urandom), rand_coef(), $urandom, $urandom, $urandom,
					2'($urandom), 2'($urandom), $urandom);
			else if (sel < 20)
				send_pair(0, 0, 0, 2'($urandom), 2'($urandom), sc);
			else if (sel < 28)
				send_pair($urandom, $urandom, $urandom, 2'($urandom), 2'($urandom), sc);
			else if (sel < 34)
				send_pair(rand_comp(64), rand_comp(64), rand_comp(64), 2'($urandom),
					2'($urandom), sc);
			else
				send_pair(rand_comp(disp_span), rand_comp(disp_span), rand_comp(disp_span),
					2'($urandom), 2'($urandom), sc);
		end
	endtask

	task automatic test_default_config();
		send_pair(32'h0010_0000, 0, 0, 0, 0, 32'h0001_0000);
		send_pair(0, 0, 0, 0, 0, 32'h0001_0000);
		send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 3, 3, 32'h8000_0000);
	endtask

	task automatic test_directed_extremes();
		send_word(CmdWrite, 0, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0);
		send_word(CmdWrite, 1, 48'h8000_0000_0000, 0, 0, 0, 0, 0, 0);
		send_word(CmdWrite, 2, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0);
		send_word(CmdWrite, 3, 48'h8000_0000_0000, 0, 0, 0, 0, 0, 0);
		send_word(CmdWrite, 16'hFFFF, 48'h0000_0001_0000, '1, '1, '1, 3, 3, '1);
		send_pair(32'h0004_8000, 0, 0, 0, 0, 32'h7FFF_FFFF);
		send_pair(0, 32'hFFFB_8000, 0, 0, 0, 32'h8000_0000);
		send_pair(32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000, 0, 0, 32'h0001_0000);
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h0001_0000);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3, 3, 32'h0001_0000);
		send_pair(0, 0, 0, 3, 0, 32'h0001_0000);
		send_pair(0, 0, 1, 0, 3, 32'h0001_0000);
		send_pair(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 3, 3, 32'hFFFF_0000);
		send_pair(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 2, 1, 32'h0000_8000);
	endtask

	task automatic test_output_stall();
		src_idle_en = 1'b0;
		hold_len = 400;
		hold_req = 1'b1;
		test_random_words(200);
		src_idle_en = 1'b1;
	endtask

	task automatic test_drain_pause();
		while (expected_pairs.size() != 0) @(negedge clk);
		test_random_words(60);
	endtask

	initial begin
		int cnt;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				cnt = 0;
				while (cnt < hold_len) begin
					@(negedge clk);
					cnt++;
				end
				hold_req = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task automatic note_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch in %s: expected %h, got %h", what, exp_v, got_v);
	endtask

	always @(posedge clk) begin : check_results
		pair_result_t e;
		logic [63:0] got [11];
		string names [11];
		names = '{"pair_energy_half", "force_scale", "force_x", "force_y", "force_z",
			"virial_xx", "virial_xy", "virial_xz", "virial_yy", "virial_yz", "virial_zz"};
		got = '{pair_energy_half, force_scale, force_x, force_y, force_z, virial_xx,
			virial_xy, virial_xz, virial_yy, virial_yz, virial_zz};
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pairs.size() == 0) begin
				note_mismatch("unexpected result word", 0, status);
			end else begin
				e = expected_pairs.pop_front();
				if (status !== e.st) note_mismatch("status", e.st, status);
				for (int k = 0; k < 11; k++)
					if (got[k] !== e.v[k]) note_mismatch(names[k], e.v[k], got[k]);
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > WatchLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_default_config();
		apply_settings(32'h0004_0000, 32'h0002_0000, 16, 4, 3 << 20);
		test_directed_extremes();
		test_random_words(150);
		apply_settings(0, 32'hFFFF_FFFF, 1024, 4, 1 << 13);
		test_random_words(60);
		apply_settings(32'hFFFF_FFFF, 0, 1, 1, 1 << 20);
		test_random_words(80);
		apply_settings(0, 0, 1, 2, 1 << 20);
		test_random_words(80);
		apply_settings(32'h0008_0000, 32'h0005_0000, 7, 3, 2 << 20);
		test_output_stall();
		test_drain_pause();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		test_random_words(200);
		while (expected_pairs.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (mismatches == 0 && expected_pairs.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/tpfe_pkg.sv
rtl/tabulated_pair_force_eval_unit.sv
tb/tb_tabulated_pair_force_eval_unit.sv
